// ===== rtl/core/golden_angle_spiral_points_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the golden-angle spiral point generator.
// These are used by the top level, which carries the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef GOLDEN_ANGLE_SPIRAL_POINTS_TOP_ASSERT_SVH
`define GOLDEN_ANGLE_SPIRAL_POINTS_TOP_ASSERT_SVH

// The condition must hold at every clock edge out of reset.
`define GASP_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error("check failed");

// The consequent must hold in the same cycle as the antecedent.
`define GASP_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

// The consequent must hold in the cycle after the antecedent.
`define GASP_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/core/gasp_pkg.sv =====
// ----------------------------------------------------------------------------
// gasp_pkg
// Types, constants and tables shared by the spiral point generator.
// ----------------------------------------------------------------------------
package gasp_pkg;

  localparam int INDEX_BITS    = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_ENTRIES  = 24;

  localparam logic [31:0]        GOLDEN_TURN   = 32'h61C88647;
  localparam logic signed [33:0] CORDIC_X0     = 34'sd652032874;
  localparam logic [15:0]        SPACING_RESET = 16'd25600;

  // Square root operand (2i+1) << 31, rounded up to an even width.
  localparam int SQ_W   = ((INDEX_BITS + 33) / 2) * 2;
  localparam int ROOT_W = SQ_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int RAD_W  = ROOT_W + 1;

  localparam int CORDIC_RUN  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
  localparam int PIPE_STAGES = (ROOT_W > CORDIC_RUN) ? ROOT_W : CORDIC_RUN;
  localparam int BACK_LAT    = PIPE_STAGES + 3;

  // A slot is held from issue to pop, which spans the back pipeline plus the
  // result queue write, so this many let issue go every cycle if pops keep up.
  localparam int OUT_DEPTH = BACK_LAT + 2;
  localparam int OUT_AW    = $clog2(OUT_DEPTH);
  localparam int CRED_W    = $clog2(OUT_DEPTH + 1);

  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TURN [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354466, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [15:0] point_index;
    coord_t      center_x;
    coord_t      center_y;
    coord_t      center_z;
    logic        last_point;
  } point_t;

  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    logic   last;
  } result_t;

  // Classified item handed from the front queue to the back pipeline.
  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic signed [33:0]    angle;
    logic                  flip;
    coord_t                cx;
    coord_t                cy;
    coord_t                cz;
    logic                  last;
  } work_t;

endpackage

// ===== rtl/core/gasp_front.sv =====
// ----------------------------------------------------------------------------
// gasp_front
// Accepts points, folds the golden angle into the right half plane and
// queues the classified work for the back pipeline.
// ----------------------------------------------------------------------------
module gasp_front
  import gasp_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  output logic   full,
  input  point_t point,
  input  logic   issue,
  output logic   avail,
  output work_t  head
);

  work_t             fq [FQ_DEPTH];
  logic [FQ_AW-1:0]  wr_ptr;
  logic [FQ_AW-1:0]  rd_ptr;
  logic [FQ_CW-1:0]  count;
  logic [INDEX_BITS-1:0] idx;
  logic [31:0]       angle_raw;
  logic [31:0]       angle_rot;
  logic [31:0]       angle_fold;
  work_t             entry;
  logic              wr_en;
  logic              rd_en;

  assign idx        = INDEX_BITS'(point.point_index);
  assign angle_raw  = 32'(GOLDEN_TURN * 32'(idx));
  assign angle_rot  = angle_raw + 32'h40000000;
  assign angle_fold = angle_rot[31] ? (angle_raw ^ 32'h80000000) : angle_raw;

  always_comb begin
    entry       = '0;
    entry.idx   = idx;
    entry.angle = {{2{angle_fold[31]}}, angle_fold};
    entry.flip  = angle_rot[31];
    entry.cx    = point.center_x;
    entry.cy    = point.center_y;
    entry.cz    = point.center_z;
    entry.last  = point.last_point;
  end

  assign full  = (count == FQ_CW'(FQ_DEPTH));
  assign avail = (count != '0);
  assign head  = fq[rd_ptr];
  assign wr_en = push && !full;
  assign rd_en = issue && avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      count <= count + FQ_CW'(wr_en) - FQ_CW'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) fq[wr_ptr] <= entry;
  end

endmodule

// ===== rtl/core/gasp_back.sv =====
// ----------------------------------------------------------------------------
// gasp_back
// Pipelined square root and CORDIC side by side, then radius scaling,
// offset multiply and saturating add. One item per cycle, fixed latency.
// ----------------------------------------------------------------------------
module gasp_back
  import gasp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  work_t       in_work,
  input  logic [15:0] spacing,
  output logic        out_valid,
  output result_t     out_result
);

  typedef struct packed {
    logic [SQ_W-1:0]    rest;
    logic [REM_W-1:0]   rem;
    logic [ROOT_W-1:0]  root;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic               flip;
    coord_t             cx;
    coord_t             cy;
    coord_t             cz;
    logic               last;
  } stage_t;

  localparam int PROD_W = 32 + RAD_W + 1;
  localparam int DX_W   = PROD_W - 30;

  function automatic stage_t stage_step(stage_t s, int k);
    stage_t             r;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] atan;
    r = s;
    if (k < ROOT_W) begin
      rem_sh = {s.rem[REM_W-3:0], s.rest[SQ_W-1 -: 2]};
      trial  = {s.root, 2'b01};
      if (rem_sh >= trial) begin
        r.rem  = rem_sh - trial;
        r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = rem_sh;
        r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      r.rest = s.rest << 2;
    end
    if (k < CORDIC_RUN) begin
      xs   = s.x >>> k;
      ys   = s.y >>> k;
      atan = $signed({2'b00, ATAN_TURN[(k < ATAN_ENTRIES) ? k : 0]});
      if (!s.z[33]) begin
        r.x = s.x - ys;
        r.y = s.y + xs;
        r.z = s.z - atan;
      end else begin
        r.x = s.x + ys;
        r.y = s.y - xs;
        r.z = s.z + atan;
      end
    end
    return r;
  endfunction

  function automatic coord_t sat32(logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return coord_t'(v[31:0]);
  endfunction

  stage_t init;
  stage_t st    [PIPE_STAGES];
  logic   st_v  [PIPE_STAGES];

  always_comb begin
    init      = '0;
    init.rest = SQ_W'({in_work.idx, 1'b1}) << 31;
    init.x    = CORDIC_X0;
    init.z    = in_work.angle;
    init.flip = in_work.flip;
    init.cx   = in_work.cx;
    init.cy   = in_work.cy;
    init.cz   = in_work.cz;
    init.last = in_work.last;
  end

  for (genvar k = 0; k < PIPE_STAGES; k++) begin : g_stage
    stage_t prev;
    logic   prev_v;
    if (k == 0) begin : g_first
      assign prev   = init;
      assign prev_v = in_valid;
    end else begin : g_rest
      assign prev   = st[k-1];
      assign prev_v = st_v[k-1];
    end
    always_ff @(posedge clk) begin
      if (rst) st_v[k] <= 1'b0;
      else     st_v[k] <= prev_v;
      st[k] <= stage_step(prev, k);
    end
  end

  // Scale stage: undo the half-turn fold and form the radius.
  stage_t                   tail;
  logic                     m1_v;
  coord_t                   m1_x;
  coord_t                   m1_y;
  logic [RAD_W-1:0]         m1_rad;
  coord_t                   m1_cx, m1_cy, m1_cz;
  logic                     m1_last;
  logic [ROOT_W+15:0]       rad_prod;

  assign tail     = st[PIPE_STAGES-1];
  assign rad_prod = (ROOT_W+16)'(spacing) * (ROOT_W+16)'(tail.root) + (ROOT_W+16)'(32768);

  always_ff @(posedge clk) begin
    if (rst) m1_v <= 1'b0;
    else     m1_v <= st_v[PIPE_STAGES-1];
    m1_x    <= tail.flip ? coord_t'(-tail.x) : coord_t'(tail.x);
    m1_y    <= tail.flip ? coord_t'(-tail.y) : coord_t'(tail.y);
    m1_rad  <= RAD_W'(rad_prod[ROOT_W+15:16]);
    m1_cx   <= tail.cx;
    m1_cy   <= tail.cy;
    m1_cz   <= tail.cz;
    m1_last <= tail.last;
  end

  // Multiply stage.
  logic                     m2_v;
  logic signed [PROD_W-1:0] m2_px, m2_py;
  coord_t                   m2_cx, m2_cy, m2_cz;
  logic                     m2_last;
  logic signed [RAD_W:0]    rad_s;

  assign rad_s = $signed({1'b0, m1_rad});

  always_ff @(posedge clk) begin
    if (rst) m2_v <= 1'b0;
    else     m2_v <= m1_v;
    m2_px   <= PROD_W'(m1_x) * PROD_W'(rad_s);
    m2_py   <= PROD_W'(m1_y) * PROD_W'(rad_s);
    m2_cx   <= m1_cx;
    m2_cy   <= m1_cy;
    m2_cz   <= m1_cz;
    m2_last <= m1_last;
  end

  // Round, add to the center and saturate.
  logic signed [PROD_W-1:0] px_r, py_r;
  logic signed [DX_W-1:0]   dx, dy;
  logic signed [33:0]       sum_x, sum_y;

  assign px_r  = m2_px + PROD_W'(1 << 29);
  assign py_r  = m2_py + PROD_W'(1 << 29);
  assign dx    = DX_W'(px_r >>> 30);
  assign dy    = DX_W'(py_r >>> 30);
  assign sum_x = 34'(m2_cx) + 34'(dx);
  assign sum_y = 34'(m2_cy) + 34'(dy);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else     out_valid <= m2_v;
    out_result.pos_x <= sat32(sum_x);
    out_result.pos_y <= sat32(sum_y);
    out_result.pos_z <= m2_cz;
    out_result.last  <= m2_last;
  end

endmodule

// ===== rtl/core/gasp_result_q.sv =====
// ----------------------------------------------------------------------------
// gasp_result_q
// Result queue that absorbs everything the back pipeline has in flight.
// ----------------------------------------------------------------------------
module gasp_result_q
  import gasp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    wr,
  input  result_t wr_data,
  input  logic    pop,
  output logic    empty,
  output logic    qfull,
  output result_t rd_data
);

  result_t           mem [OUT_DEPTH];
  logic [OUT_AW-1:0] wr_ptr;
  logic [OUT_AW-1:0] rd_ptr;
  logic [CRED_W-1:0] count;
  logic              rd_en;

  assign empty   = (count == '0);
  assign qfull   = (count == CRED_W'(OUT_DEPTH));
  assign rd_data = mem[rd_ptr];
  assign rd_en   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == OUT_AW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CRED_W'(wr) - CRED_W'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== rtl/core/golden_angle_spiral_points_top.sv =====
// Golden-angle spiral point generator.
// Input side is a queue: drive point and raise push; the beat is taken on a
// rising edge with push high and full low. One point index and center go in,
// one spiral position comes out, in order, with last copied through.
// Result side is a queue too: while empty is low, result holds the oldest
// beat, and it is taken on a rising edge with pop high.
// The spacing register is written through cfg_valid/cfg_data; cfg_ready is
// always high. Write it only while no item is in flight.
// Throughput is one point per cycle while results are popped as they appear.
// A point reaches the result ports through the front queue, the back pipeline
// and the result queue. The back pipeline is max(square root steps, CORDIC
// stages) plus three, so with 16 index bits it takes 24 square root steps.
// The back pipeline only issues an item when the result queue has a slot
// reserved for it, so a stalled receiver fills the result queue, then the
// small front queue, and then full rises. Nothing is dropped.
// Synchronous reset empties both queues and the pipeline and sets spacing
// back to 100.0 world units.
// ----------------------------------------------------------------------------
// golden_angle_spiral_points_top
// Top level: front queue, back pipeline, result queue and slot credits.
// ----------------------------------------------------------------------------
module golden_angle_spiral_points_top
  import gasp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  point_t      point,
  output logic        empty,
  input  logic        pop,
  output result_t     result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic [15:0]       spacing;
  logic              avail;
  logic              issue;
  work_t             head;
  logic              back_valid;
  result_t           back_result;
  logic              rq_full;
  logic [CRED_W-1:0] credits_used;
  logic              pop_beat;

  // The configuration channel never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (cfg_valid && cfg_ready) begin
      spacing <= cfg_data;
    end
  end

  // Every issued item owns a result queue slot from issue until its pop,
  // which is why the back pipeline never needs to stall.
  assign pop_beat = pop && !empty;
  assign issue    = avail && (credits_used < CRED_W'(OUT_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      credits_used <= '0;
    end else begin
      credits_used <= credits_used + CRED_W'(issue) - CRED_W'(pop_beat);
    end
  end

  gasp_front u_front (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .full  (full),
    .point (point),
    .issue (issue),
    .avail (avail),
    .head  (head)
  );

  gasp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (issue),
    .in_work    (head),
    .spacing    (spacing),
    .out_valid  (back_valid),
    .out_result (back_result)
  );

  gasp_result_q u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr      (back_valid),
    .wr_data (back_result),
    .pop     (pop),
    .empty   (empty),
    .qfull   (rq_full),
    .rd_data (result)
  );

`include "golden_angle_spiral_points_top_assert.svh"

  // Slot credits can never exceed the result queue depth.
  `GASP_ALWAYS(a_credit_bound, credits_used <= CRED_W'(OUT_DEPTH))
  // The pipeline must never write into a full result queue.
  `GASP_IMPLIES(a_no_overflow, back_valid, !rq_full)
  // With every slot reserved, nothing may be issued.
  `GASP_IMPLIES(a_no_issue_when_spent, credits_used == CRED_W'(OUT_DEPTH), !issue)

endmodule
